// ===== rtl/depth_tested_framebuffer_defines.svh =====
// assertion macros used by the framebuffer checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef DEPTH_TESTED_FRAMEBUFFER_DEFINES_SVH
`define DEPTH_TESTED_FRAMEBUFFER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define DTFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define DTFB_ASSERT_NEVER(label, cond, msg) \
  `DTFB_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/dtfb_pkg.sv =====
// shared types and constants of the depth tested framebuffer
// no dependencies; used by the store, the top level and the checker
package dtfb_pkg;

  localparam int ScreenWidthDef  = 256;
  localparam int ScreenHeightDef = 256;

  localparam int DepthW = 24;
  localparam int ChanW  = 16;

  localparam logic signed [DepthW-1:0] DepthMax = 24'sh7FFFFF;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_WRITTEN      = 3'd0,
    ST_DEPTH_REJECT = 3'd1,
    ST_OFF_SCREEN   = 3'd2,
    ST_READ_DONE    = 3'd3,
    ST_CLEAR_DONE   = 3'd4
  } status_e;

  // one stored pixel: depth and color side by side
  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
  } pixel_t;

  localparam pixel_t PixelCleared = '{
    depth: DepthMax,
    red:   '0,
    green: '0,
    blue:  '0
  };

endpackage

// ===== rtl/dtfb_store.sv =====
// pixel store of the framebuffer: one write port, one registered read port
// depends on dtfb_pkg for the pixel type
module dtfb_store import dtfb_pkg::*; #(
  parameter int Depth = ScreenWidthDef * ScreenHeightDef,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  pixel_t           wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output pixel_t           rdata_o
);

  pixel_t mem [Depth];
  pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/depth_tested_framebuffer.sv =====
// Z-buffered framebuffer. Each accepted command gives exactly one result. A
// write or read command first reads the pixel store at transfer (a synchronous
// read), then does the depth compare and write-back as its result is
// registered; the store has a single read and a single write port and one
// command is in flight at a time, so no new command is taken until the last
// one has reached the result register. A clear command sweeps the store one
// pixel per cycle and then gives its result. After reset the same sweep runs
// with the input stalled and gives no result. Depends on dtfb_pkg and dtfb_store.
module depth_tested_framebuffer import dtfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic signed [15:0]       pixel_x_i,
  input  logic signed [15:0]       pixel_y_i,
  input  logic signed [DepthW-1:0] frag_depth_i,
  input  logic [ChanW-1:0]         frag_red_i,
  input  logic [ChanW-1:0]         frag_green_i,
  input  logic [ChanW-1:0]         frag_blue_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [ChanW-1:0]         read_red_o,
  output logic [ChanW-1:0]         read_green_o,
  output logic [ChanW-1:0]         read_blue_o,
  output logic signed [DepthW-1:0] read_depth_o
);

  localparam int PixelCount = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AddrW      = (PixelCount > 1) ? $clog2(PixelCount) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(PixelCount - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_CLEAR  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clr_report_q, clr_report_d;

  // command held while it is in flight
  logic [1:0]        op_q;
  logic              on_q;
  logic [AddrW-1:0]  addr_q;
  logic [DepthW-1:0] depth_q;
  logic [ChanW-1:0]  red_q, green_q, blue_q;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        status_q, status_d;
  pixel_t            res_q, res_d;

  logic              in_xfer;
  logic              in_on;
  logic [31:0]       in_index;
  logic [AddrW-1:0]  in_addr;
  logic              load;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [AddrW-1:0]  raddr;
  pixel_t            wdata;
  pixel_t            rdata;
  logic              depth_pass;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_on = !pixel_x_i[15] && (pixel_x_i < 16'(SCREEN_WIDTH)) &&
                 !pixel_y_i[15] && (pixel_y_i < 16'(SCREEN_HEIGHT));

  assign in_index = 32'($unsigned(pixel_y_i)) * 32'(SCREEN_WIDTH)
                  + 32'($unsigned(pixel_x_i));
  assign in_addr  = in_index[AddrW-1:0];

  // the store is read at transfer; the address is held while the result waits
  assign raddr = (state_q == S_IDLE) ? in_addr : addr_q;

  // result register takes the command once it is free or draining
  assign load = (state_q == S_LOOKUP) && (!out_valid_q || !out_stall_i);

  assign depth_pass = $signed(depth_q) < $signed(rdata.depth);

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = '{depth: depth_q, red: red_q, green: green_q, blue: blue_q};
    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = PixelCleared;
    end else if (load && on_q && (op_q == OP_WRITE) && depth_pass) begin
      we = 1'b1;
    end
  end

  dtfb_store #(
    .Depth (PixelCount),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    status_d = ST_OFF_SCREEN;
    res_d    = '0;
    case (op_q)
      OP_WRITE: begin
        if (on_q) begin
          status_d = depth_pass ? ST_WRITTEN : ST_DEPTH_REJECT;
        end
      end
      OP_READ: begin
        if (on_q) begin
          status_d = ST_READ_DONE;
          res_d    = rdata;
        end
      end
      OP_CLEAR: begin
        status_d = ST_CLEAR_DONE;
      end
      default: begin
        status_d = ST_OFF_SCREEN;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    clr_report_d = clr_report_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (opcode_i == OP_CLEAR) begin
            state_d      = S_CLEAR;
            clr_addr_d   = '0;
            clr_report_d = 1'b1;
          end else begin
            state_d = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (clr_addr_q == LastAddr) begin
          // the sweep after reset reports nothing
          state_d      = clr_report_q ? S_LOOKUP : S_IDLE;
          clr_addr_d   = '0;
          clr_report_d = 1'b0;
        end else begin
          clr_addr_d = clr_addr_q + AddrW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      clr_report_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      clr_report_q <= clr_report_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= opcode_i;
      on_q    <= in_on;
      addr_q  <= in_addr;
      depth_q <= frag_depth_i;
      red_q   <= frag_red_i;
      green_q <= frag_green_i;
      blue_q  <= frag_blue_i;
    end
    if (load) begin
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_red_o   = res_q.red;
  assign read_green_o = res_q.green;
  assign read_blue_o  = res_q.blue;
  assign read_depth_o = $signed(res_q.depth);

endmodule

// ===== rtl/dtfb_checker.sv =====
// port-level checks of the depth tested framebuffer, bound to the top level
// depends on dtfb_pkg and the assertion macros in the defines header
`include "depth_tested_framebuffer_defines.svh"

module dtfb_checker import dtfb_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [1:0]               opcode_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [2:0]               status_o,
  input logic [ChanW-1:0]         read_red_o,
  input logic [ChanW-1:0]         read_green_o,
  input logic [ChanW-1:0]         read_blue_o,
  input logic signed [DepthW-1:0] read_depth_o
);

  logic                        in_xfer;
  logic                        clr_xfer;
  logic                        read_fields_zero;
  logic                        stray_fields;
  logic                        out_wait;
  logic [3*ChanW+DepthW+2:0]   out_word;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign clr_xfer = in_xfer && (opcode_i == OP_CLEAR);
  assign read_fields_zero = (read_red_o == '0) && (read_green_o == '0) &&
                            (read_blue_o == '0) && (read_depth_o == '0);
  assign stray_fields = out_valid_o && (status_o != ST_READ_DONE) && !read_fields_zero;
  assign out_wait = out_valid_o && out_stall_i;
  assign out_word = {status_o, read_red_o, read_green_o, read_blue_o, read_depth_o};

  // one command in flight: the input closes right after a transfer
  `DTFB_ASSERT(a_one_in_flight, in_xfer |=> in_stall_o, "second command taken while busy")

  // a clear keeps the input closed early in the sweep (checked at a single sample)
  `DTFB_ASSERT(a_clear_holds, clr_xfer |=> ##1 in_stall_o, "input open during clear")

  // only a finished read carries pixel data
  `DTFB_ASSERT_NEVER(a_read_fields, stray_fields, "read fields set on a non-read result")

  // a stalled result stays put
  `DTFB_ASSERT(a_out_hold, out_wait |=> out_valid_o && $stable(out_word), "stalled result moved")

endmodule

bind depth_tested_framebuffer dtfb_checker u_dtfb_checker (.*);
